// ----- design/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper.
// Used by jsu_decode and json_string_unescape_utf8_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   // Result status codes.
   localparam logic [1:0] ST_DATA = 2'd0;
   localparam logic [1:0] ST_END  = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   localparam int LEN_W     = 16;
   localparam int GROUP_MAX = 4;

   // Characters that steer the decoder.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   // All results caused by one input byte.
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] data_bytes;
      logic [1:0]                status;
      logic [LEN_W-1:0]          len;
      logic [2:0]                count;
   } grp_type;

   // Returns {valid, nibble} for an ASCII hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         r = {1'b1, 4'(ch - 8'h37)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         r = {1'b1, 4'(ch - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/jsu_decode.sv -----
// Decoder state machine: turns one literal byte into a group of 0 to 4 results.
// Holds the mode, the two code units and the length count. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode import jsu_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] byte_i,
   input  wire logic       advance,
   output grp_type         grp_o
);

   localparam int CNT_W = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;

   typedef enum logic [12:0] {
      MD_IDLE = 13'h0001,
      MD_BODY = 13'h0002,
      MD_ESC  = 13'h0004,
      MD_H1   = 13'h0008,
      MD_H2   = 13'h0010,
      MD_H3   = 13'h0020,
      MD_H4   = 13'h0040,
      MD_BSL  = 13'h0080,
      MD_LU   = 13'h0100,
      MD_L1   = 13'h0200,
      MD_L2   = 13'h0400,
      MD_L3   = 13'h0800,
      MD_L4   = 13'h1000
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [15:0]      fcu_ff, fcu_in;
   logic [15:0]      scu_ff, scu_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [4:0]       hx;
   logic [15:0]      fcu_sh, scu_sh;
   logic [20:0]      cp;
   logic [2:0]       ndata;
   logic             clear_cnt;
   logic [CNT_W+2:0] cnt_sum;
   logic [CNT_W-1:0] cnt_cap;

   assign hx      = hex_decode(byte_i);
   assign fcu_sh  = {fcu_ff[11:0], hx[3:0]};
   assign scu_sh  = {scu_ff[11:0], hx[3:0]};
   // Supplementary code point from a surrogate pair.
   assign cp      = {1'b0, fcu_ff[9:0], scu_sh[9:0]} + 21'h10000;
   assign cnt_cap = {CNT_W{1'b1}};
   assign cnt_sum = {3'b000, cnt_ff} + {{CNT_W{1'b0}}, ndata};

   always_comb begin
      mode_in   = mode_ff;
      fcu_in    = fcu_ff;
      scu_in    = scu_ff;
      clear_cnt = 1'b0;
      ndata     = 3'd0;
      grp_o     = '0;

      case (mode_ff)
         MD_IDLE: begin
            if (byte_i == CH_QUOTE) begin
               clear_cnt = 1'b1;
               mode_in   = MD_BODY;
            end
         end
         MD_BODY: begin
            if (byte_i == CH_NUL) begin
               grp_o.status = ST_ERR;
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end else if (byte_i == CH_QUOTE) begin
               grp_o.status = ST_END;
               grp_o.len    = LEN_W'(cnt_ff);
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end else if (byte_i == CH_BSL) begin
               mode_in = MD_ESC;
            end else begin
               grp_o.data_bytes[0] = byte_i;
               grp_o.count         = 3'd1;
               ndata               = 3'd1;
            end
         end
         MD_ESC: begin
            mode_in = MD_BODY;
            ndata   = 3'd1;
            case (byte_i)
               CH_QUOTE: grp_o.data_bytes[0] = CH_QUOTE;
               CH_BSL:   grp_o.data_bytes[0] = CH_BSL;
               CH_B:     grp_o.data_bytes[0] = 8'h08;
               CH_F:     grp_o.data_bytes[0] = 8'h0C;
               CH_N:     grp_o.data_bytes[0] = 8'h0A;
               CH_R:     grp_o.data_bytes[0] = 8'h0D;
               CH_T:     grp_o.data_bytes[0] = 8'h09;
               CH_U: begin
                  ndata   = 3'd0;
                  fcu_in  = 16'h0000;
                  mode_in = MD_H1;
               end
               default: begin
                  ndata        = 3'd0;
                  grp_o.status = ST_ERR;
                  mode_in      = MD_IDLE;
               end
            endcase
            grp_o.count = (grp_o.status == ST_ERR) ? 3'd1 : ndata;
         end
         MD_H1, MD_H2, MD_H3: begin
            if (!hx[4]) begin
               grp_o.status = ST_ERR;
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end else begin
               fcu_in  = fcu_sh;
               mode_in = (mode_ff == MD_H1) ? MD_H2 : ((mode_ff == MD_H2) ? MD_H3 : MD_H4);
            end
         end
         MD_H4: begin
            if (!hx[4]) begin
               grp_o.status = ST_ERR;
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end else begin
               fcu_in  = fcu_sh;
               mode_in = MD_BODY;
               if (fcu_sh < 16'h0080) begin
                  grp_o.data_bytes[0] = fcu_sh[7:0];
                  ndata               = 3'd1;
               end else if (fcu_sh < 16'h0800) begin
                  grp_o.data_bytes[0] = {3'b110, fcu_sh[10:6]};
                  grp_o.data_bytes[1] = {2'b10, fcu_sh[5:0]};
                  ndata               = 3'd2;
               end else if (fcu_sh >= 16'hD800 && fcu_sh < 16'hDC00) begin
                  // High surrogate: a low one must follow.
                  mode_in = MD_BSL;
               end else begin
                  grp_o.data_bytes[0] = {4'b1110, fcu_sh[15:12]};
                  grp_o.data_bytes[1] = {2'b10, fcu_sh[11:6]};
                  grp_o.data_bytes[2] = {2'b10, fcu_sh[5:0]};
                  ndata               = 3'd3;
               end
               grp_o.count = ndata;
            end
         end
         MD_BSL: begin
            if (byte_i == CH_BSL) begin
               mode_in = MD_LU;
            end else begin
               grp_o.status = ST_ERR;
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end
         end
         MD_LU: begin
            if (byte_i == CH_U) begin
               scu_in  = 16'h0000;
               mode_in = MD_L1;
            end else begin
               grp_o.status = ST_ERR;
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end
         end
         MD_L1, MD_L2, MD_L3: begin
            if (!hx[4]) begin
               grp_o.status = ST_ERR;
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end else begin
               scu_in  = scu_sh;
               mode_in = (mode_ff == MD_L1) ? MD_L2 : ((mode_ff == MD_L2) ? MD_L3 : MD_L4);
            end
         end
         MD_L4: begin
            if (!hx[4]) begin
               grp_o.status = ST_ERR;
               grp_o.count  = 3'd1;
               mode_in      = MD_IDLE;
            end else begin
               scu_in = scu_sh;
               if (scu_sh < 16'hDC00 || scu_sh > 16'hDFFF) begin
                  grp_o.status = ST_ERR;
                  grp_o.count  = 3'd1;
                  mode_in      = MD_IDLE;
               end else begin
                  grp_o.data_bytes[0] = {5'b11110, cp[20:18]};
                  grp_o.data_bytes[1] = {2'b10, cp[17:12]};
                  grp_o.data_bytes[2] = {2'b10, cp[11:6]};
                  grp_o.data_bytes[3] = {2'b10, cp[5:0]};
                  ndata               = 3'd4;
                  grp_o.count         = 3'd4;
                  mode_in             = MD_BODY;
               end
            end
         end
         default: begin
            mode_in = MD_IDLE;
         end
      endcase

      if (clear_cnt) begin
         cnt_in = '0;
      end else if (cnt_sum > {3'b000, cnt_cap}) begin
         cnt_in = cnt_cap;
      end else begin
         cnt_in = cnt_sum[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MD_IDLE;
         fcu_ff  <= 16'h0000;
         scu_ff  <= 16'h0000;
         cnt_ff  <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         fcu_ff  <= fcu_in;
         scu_ff  <= scu_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/json_string_unescape_utf8_top.sv -----
// Top level of the JSON string unescaper: input register, decoder, result buffer.
// Depends on jsu_pkg and jsu_decode.
//
// Usage: bytes of a JSON string literal, opening quote first, arrive on the req_
// channel, one byte per transfer. Decoded UTF-8 bytes, an end result carrying the
// saturated length, or an error result leave on the rsp_ channel. rsp_last marks
// the final result caused by one input byte; bytes that cause no result (idle
// bytes, the opening quote, escape and hex digits) produce nothing on rsp_.
// A byte taken sits in the input register, is decoded into the result buffer
// once the buffer is free, and its first result is then offered from the buffer.
// Throughput is one byte per cycle while each byte gives at most one result and
// the receiver takes every result. A byte that gives k results (up to four for a
// surrogate pair) occupies the result buffer for k result transfers, which is
// what limits the rate.
// While the receiver stalls, the input register still takes one more byte, so
// the sender is held off only once both the buffer and the input register hold
// work. After reset the decoder waits for an opening quote, the length count is
// zero and both the input register and the result buffer are empty.
// An error result sends the decoder back to wait for a new opening quote.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_in_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_status,
   output logic [LEN_W-1:0]      rsp_string_length,
   output logic                  rsp_last
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Result buffer holding the group of results of one byte.
   grp_type    grp_ff, grp_in;
   logic       grp_valid_ff, grp_valid_in;
   logic [1:0] idx_ff, idx_in;

   grp_type    dec_grp;
   logic       rsp_xfer;
   logic       grp_free;
   logic       load;

   jsu_decode #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .byte_i (in_byte_ff),
      .advance(load),
      .grp_o  (dec_grp)
   );

   assign rsp_xfer  = rsp_valid && rsp_ready;
   // The buffer is free when empty or when its final result transfers now.
   assign grp_free  = !grp_valid_ff || (rsp_xfer && rsp_last);
   assign load      = in_valid_ff && grp_free;
   assign req_ready = !in_valid_ff || load;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      grp_in       = grp_ff;
      grp_valid_in = grp_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         grp_in       = dec_grp;
         grp_valid_in = (dec_grp.count != 3'd0);
         idx_in       = 2'd0;
      end else if (rsp_xfer) begin
         if (rsp_last) begin
            grp_valid_in = 1'b0;
         end
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         grp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      grp_ff     <= grp_in;
   end

   assign rsp_valid         = grp_valid_ff;
   assign rsp_out_byte      = (grp_ff.status == ST_DATA) ? grp_ff.data_bytes[idx_ff] : 8'h00;
   assign rsp_status        = grp_ff.status;
   assign rsp_string_length = grp_ff.len;
   assign rsp_last          = ({1'b0, idx_ff} + 3'd1) == grp_ff.count;

   // The read position always lies inside the stored group.
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> ({1'b0, idx_ff} < grp_ff.count))
      else $error("result index beyond group size");

   // End and error groups carry exactly one result.
   a_single_ctrl: assert property (@(posedge clock) disable iff (reset)
      (grp_valid_ff && grp_ff.status != ST_DATA) |-> (grp_ff.count == 3'd1))
      else $error("end or error group with more than one result");

   // A new group never overwrites results that have not all been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load && grp_valid_ff) |-> (rsp_ready && rsp_last))
      else $error("result group overwritten before drained");

endmodule

`default_nettype wire
